FILE: hw/rtl/bpc_pkg.sv
`default_nettype none

package bpc_pkg;

	localparam int TIMER_WIDTH_DEF = 16;

	localparam int REG_W   = 16;
	localparam int ADDR_W  = 8;
	localparam int IN_TDATA_W  = 8;
	localparam int OUT_TDATA_W = 8;
	localparam int RES_W   = 4;

	// register indexes on the config port
	localparam logic [ADDR_W-1:0] REG_ACTIVE_LOW     = 8'd0;
	localparam logic [ADDR_W-1:0] REG_DEBOUNCE_TICKS = 8'd1;
	localparam logic [ADDR_W-1:0] REG_DOUBLE_TICKS   = 8'd2;
	localparam logic [ADDR_W-1:0] REG_LONG_TICKS     = 8'd3;

	localparam logic [REG_W-1:0] DEBOUNCE_RESET = 16'd50;
	localparam logic [REG_W-1:0] DOUBLE_RESET   = 16'd300;
	localparam logic [REG_W-1:0] LONG_RESET     = 16'd1000;

	typedef struct packed {
		logic             active_low;
		logic [REG_W-1:0] debounce_ticks;
		logic [REG_W-1:0] double_window_ticks;
		logic [REG_W-1:0] long_ticks;
	} cfg_t;

	typedef struct packed {
		logic long_press;
		logic double_press;
		logic short_press;
		logic pressed;
	} res_t;

endpackage

`default_nettype wire

FILE: hw/rtl/bpc_fsm.sv
`default_nettype none

module bpc_fsm #(
	parameter int TIMER_WIDTH = bpc_pkg::TIMER_WIDTH_DEF
) (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire logic          tick,
	input  wire logic          level,
	input  wire bpc_pkg::cfg_t cfg,
	output bpc_pkg::res_t      res
);

	localparam int TW = TIMER_WIDTH;
	localparam int LW = (TW > bpc_pkg::REG_W) ? TW : bpc_pkg::REG_W;
	localparam logic [TW-1:0] TMASK = '1;

	typedef enum logic [7:0] {
		ST_RELEASED   = 8'b0000_0001,
		ST_DEBOUNCE   = 8'b0000_0010,
		ST_SHORT      = 8'b0000_0100,
		ST_AWAIT      = 8'b0000_1000,
		ST_DEB_DOUBLE = 8'b0001_0000,
		ST_DOUBLE     = 8'b0010_0000,
		ST_LONG       = 8'b0100_0000,
		ST_IGNORE     = 8'b1000_0000
	} state_t;

	state_t        st_q, st_d;
	logic          last_q, last_d;
	logic          primed_q, primed_d;
	logic [TW-1:0] cd_q, cd_d;
	logic          run_q, run_d;
	logic [TW-1:0] sr_q, sr_d;
	logic          p_short, p_double, p_long;

	logic          press;
	logic [TW-1:0] sr_inc;
	logic [LW-1:0] dw_ext, sr_ext, dw_left, long_left;
	logic          dw_gt;

	// zero raised to one, oversize clipped to the timer range
	function automatic logic [TW-1:0] sat_load(input logic [LW-1:0] t);
		if (t == '0)
			return TW'(1);
		else if (t > LW'(TMASK))
			return TMASK;
		else
			return TW'(t);
	endfunction

	assign press  = level ^ cfg.active_low;
	assign sr_inc = (sr_q != TMASK) ? sr_q + TW'(1) : sr_q;
	assign dw_ext = LW'(cfg.double_window_ticks);
	assign sr_ext = LW'(sr_inc);
	assign dw_gt  = dw_ext > sr_ext;
	assign dw_left = dw_ext - sr_ext;
	assign long_left = (cfg.long_ticks > cfg.debounce_ticks) ?
		LW'(cfg.long_ticks - cfg.debounce_ticks) : LW'(1);

	always_comb begin
		st_d     = st_q;
		last_d   = last_q;
		primed_d = primed_q;
		cd_d     = cd_q;
		run_d    = run_q;
		sr_d     = sr_q;
		p_short  = 1'b0;
		p_double = 1'b0;
		p_long   = 1'b0;
		if (!primed_q) begin
			// first tick only latches the line; a held button is ignored until release
			primed_d = 1'b1;
			last_d   = level;
			if (level != cfg.active_low)
				st_d = ST_IGNORE;
		end else begin
			sr_d = sr_inc;
			// timer expiry goes before the edge
			if (run_q) begin
				cd_d = cd_q - TW'(1);
				if (cd_d == '0) begin
					run_d = 1'b0;
					unique case (st_q)
						ST_DEBOUNCE: begin
							st_d  = ST_SHORT;
							cd_d  = sat_load(long_left);
							run_d = 1'b1;
						end
						ST_SHORT: begin
							st_d   = ST_LONG;
							p_long = 1'b1;
						end
						ST_AWAIT: begin
							st_d    = ST_RELEASED;
							p_short = 1'b1;
						end
						ST_DEB_DOUBLE: begin
							st_d     = ST_DOUBLE;
							p_double = 1'b1;
						end
						default: ;
					endcase
				end
			end
			if (level != last_q) begin
				last_d = level;
				unique case (st_d)
					ST_RELEASED: begin
						if (press) begin
							st_d  = ST_DEBOUNCE;
							cd_d  = sat_load(LW'(cfg.debounce_ticks));
							run_d = 1'b1;
						end
					end
					ST_DEBOUNCE: begin
						if (!press) begin
							st_d  = ST_RELEASED;
							run_d = 1'b0;
						end
					end
					ST_SHORT: begin
						if (!press) begin
							st_d  = ST_AWAIT;
							sr_d  = '0;
							cd_d  = sat_load(dw_ext);
							run_d = 1'b1;
						end
					end
					ST_AWAIT: begin
						if (press) begin
							st_d  = ST_DEB_DOUBLE;
							cd_d  = sat_load(LW'(cfg.debounce_ticks));
							run_d = 1'b1;
						end
					end
					ST_DEB_DOUBLE: begin
						if (!press) begin
							// bounce inside the double window: resume waiting for what is left
							if (dw_gt) begin
								st_d  = ST_AWAIT;
								cd_d  = sat_load(dw_left);
								run_d = 1'b1;
							end else begin
								st_d    = ST_RELEASED;
								run_d   = 1'b0;
								p_short = 1'b1;
							end
						end
					end
					default: begin
						if (!press)
							st_d = ST_RELEASED;
					end
				endcase
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q     <= ST_RELEASED;
			last_q   <= 1'b0;
			primed_q <= 1'b0;
			cd_q     <= '0;
			run_q    <= 1'b0;
			sr_q     <= '0;
		end else if (tick) begin
			st_q     <= st_d;
			last_q   <= last_d;
			primed_q <= primed_d;
			cd_q     <= cd_d;
			run_q    <= run_d;
			sr_q     <= sr_d;
		end
	end

	assign res.pressed = (st_d == ST_DEBOUNCE) || (st_d == ST_SHORT) ||
		(st_d == ST_DEB_DOUBLE) || (st_d == ST_DOUBLE) || (st_d == ST_LONG);
	assign res.short_press  = p_short;
	assign res.double_press = p_double;
	assign res.long_press   = p_long;

	a_run_matches_state: assert property (@(posedge clk) disable iff (!arst_n)
		run_q == ((st_q == ST_DEBOUNCE) || (st_q == ST_SHORT) ||
			(st_q == ST_AWAIT) || (st_q == ST_DEB_DOUBLE)))
		else $error("timer running flag disagrees with state");

	a_run_nonzero: assert property (@(posedge clk) disable iff (!arst_n)
		run_q |-> (cd_q != '0))
		else $error("running timer holds zero");

	a_unprimed_idle: assert property (@(posedge clk) disable iff (!arst_n)
		!primed_q |-> (st_q == ST_RELEASED && !run_q))
		else $error("state moved before first tick");

endmodule

`default_nettype wire

FILE: hw/rtl/button_press_classifier.sv
// button press classifier
// s_* stream: one beat per timer tick, s_tdata[0] is the raw button line level.
// m_* stream: one beat per input beat, in order: pressed (bit 0), then one-tick
// pulses short_press, double_press and long_press (bits 1 to 3).
// cfg_* port: write register cfg_addr with cfg_data (0 active_low, 1 debounce
// ticks, 2 double window ticks, 3 long ticks); other indexes are dropped.
// cfg_ready is always high; write only while no beats are in flight.
// result of a tick is registered into the output register (skid register if one waits).
// throughput: one beat per cycle while s_tready is high; the state machine, timer and
// since-release counter are updated together from each accepted beat.
// a two-entry output stage (output register plus skid register) lets an input
// beat in while a result waits; s_tready drops only once both entries are full.
// reset: registers return to 0, 50, 300, 1000, the output stage empties, and
// the first tick after reset only latches the line level (a button already
// held is ignored until it is released).

`default_nettype none

module button_press_classifier #(
	parameter int TIMER_WIDTH = bpc_pkg::TIMER_WIDTH_DEF
) (
	input  wire logic                             clk,
	input  wire logic                             arst_n,
	input  wire logic                             s_tvalid,
	output logic                                  s_tready,
	input  wire logic [bpc_pkg::IN_TDATA_W-1:0]   s_tdata,  // [0] level
	output logic                                  m_tvalid,
	input  wire logic                             m_tready,
	output logic [bpc_pkg::OUT_TDATA_W-1:0]       m_tdata,  // [0] pressed, [1] short_press,
	                                                        // [2] double_press, [3] long_press
	input  wire logic                             cfg_valid,
	output logic                                  cfg_ready,
	input  wire logic [bpc_pkg::ADDR_W-1:0]       cfg_addr,
	input  wire logic [bpc_pkg::REG_W-1:0]        cfg_data
);

	bpc_pkg::cfg_t cfg_q;
	bpc_pkg::res_t res;
	bpc_pkg::res_t out_q, skid_q;
	logic          out_vld_q, skid_vld_q;
	logic          in_beat, out_beat, cfg_beat;

	assign cfg_ready = 1'b1;
	assign cfg_beat  = cfg_valid && cfg_ready;
	assign s_tready  = !skid_vld_q;
	assign in_beat   = s_tvalid && s_tready;
	assign out_beat  = m_tvalid && m_tready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.active_low          <= 1'b0;
			cfg_q.debounce_ticks      <= bpc_pkg::DEBOUNCE_RESET;
			cfg_q.double_window_ticks <= bpc_pkg::DOUBLE_RESET;
			cfg_q.long_ticks          <= bpc_pkg::LONG_RESET;
		end else if (cfg_beat) begin
			unique case (cfg_addr)
				bpc_pkg::REG_ACTIVE_LOW:     cfg_q.active_low          <= cfg_data[0];
				bpc_pkg::REG_DEBOUNCE_TICKS: cfg_q.debounce_ticks      <= cfg_data;
				bpc_pkg::REG_DOUBLE_TICKS:   cfg_q.double_window_ticks <= cfg_data;
				bpc_pkg::REG_LONG_TICKS:     cfg_q.long_ticks          <= cfg_data;
				default: ;
			endcase
		end
	end

	bpc_fsm #(
		.TIMER_WIDTH(TIMER_WIDTH)
	) u_fsm (
		.clk   (clk),
		.arst_n(arst_n),
		.tick  (in_beat),
		.level (s_tdata[0]),
		.cfg   (cfg_q),
		.res   (res)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_vld_q  <= 1'b0;
			skid_vld_q <= 1'b0;
		end else if (skid_vld_q) begin
			if (out_beat)
				skid_vld_q <= 1'b0;
		end else if (in_beat) begin
			if (out_vld_q && !out_beat)
				skid_vld_q <= 1'b1;
			else
				out_vld_q <= 1'b1;
		end else if (out_beat) begin
			out_vld_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (skid_vld_q) begin
			if (out_beat)
				out_q <= skid_q;
		end else if (in_beat) begin
			if (out_vld_q && !out_beat)
				skid_q <= res;
			else
				out_q <= res;
		end
	end

	assign m_tvalid = out_vld_q;
	assign m_tdata  = {{(bpc_pkg::OUT_TDATA_W - bpc_pkg::RES_W){1'b0}}, out_q};

	a_skid_behind_out: assert property (@(posedge clk) disable iff (!arst_n)
		skid_vld_q |-> out_vld_q)
		else $error("skid entry held with empty output register");

	a_one_pulse: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> $onehot0({out_q.short_press, out_q.double_press, out_q.long_press}))
		else $error("more than one press pulse in a beat");

	a_full_no_accept: assert property (@(posedge clk) disable iff (!arst_n)
		(out_vld_q && skid_vld_q) |-> !s_tready)
		else $error("input taken with output stage full");

endmodule

`default_nettype wire
